// ===== src/separable_switch_allocator_macros.svh =====
// Assertion helpers shared by the allocator's RTL.
`ifndef SEPARABLE_SWITCH_ALLOCATOR_MACROS_SVH
`define SEPARABLE_SWITCH_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked once reset is released.
`define SSA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, checked once reset is released.
`define SSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// ===== src/ssa_pkg.sv =====
package ssa_pkg;

  // Router geometry.
  localparam int NUM_PORTS = 5;
  localparam int NUM_VCS   = 4;
  localparam int PORT_W    = 3;
  localparam int VC_W      = 2;

  localparam int ELIG_W    = NUM_PORTS * NUM_VCS;
  localparam int TARGET_W  = ELIG_W * PORT_W;

  // One request beat: eligibility and target port of every input VC.
  typedef struct packed {
    logic [ELIG_W-1:0]   vc_eligible;
    logic [TARGET_W-1:0] vc_target_ports;
  } in_beat_t;

  // One grant beat: per output port, valid, winning input port and VC.
  typedef struct packed {
    logic [NUM_PORTS-1:0]        grant_valid;
    logic [NUM_PORTS*PORT_W-1:0] grant_inports;
    logic [NUM_PORTS*VC_W-1:0]   grant_vcs;
  } out_beat_t;

endpackage

// ===== src/ssa_rr_arb.sv =====
// Round-robin picker: grants the first request at or after the pointer.
module ssa_rr_arb #(
  parameter int N  = 4,
  parameter int IW = (N > 1) ? $clog2(N) : 1
) (
  input  logic [N-1:0]  req,
  input  logic [IW-1:0] ptr,
  output logic          gnt,
  output logic [IW-1:0] idx
);

  // Walk the requests from the pointer on, wrapping at N.
  always_comb begin : scan
    logic [IW:0] pos;
    gnt = 1'b0;
    idx = '0;
    pos = '0;
    for (int k = 0; k < N; k++) begin
      pos = {1'b0, ptr} + (IW + 1)'(k);
      if (pos >= (IW + 1)'(N)) begin
        pos = pos - (IW + 1)'(N);
      end
      if (!gnt && req[pos[IW-1:0]]) begin
        gnt = 1'b1;
        idx = pos[IW-1:0];
      end
    end
  end

endmodule

// ===== src/separable_switch_allocator.sv =====
// Separable input-first round-robin switch allocator.
// Input channel (in_valid / in_stall / in_data): one request beat per
// allocation, carrying the eligible bit and target output port of every
// input VC. Result channel (out_valid / out_stall / out_data): one grant beat
// per request beat, giving per output port a valid bit, the winning input
// port and its VC; slots of ungranted outputs are zero.
// A request beat is held in the input register and its grant beat in the
// output register. Throughput is one beat per cycle while out_stall is low:
// the whole allocation, both arbitration stages and the pointer update, is
// done combinationally between the input register and the output register,
// and the round-robin pointers are read there and updated as the beat advances.
// Reset clears the valid bits of both beat registers and zeroes every VC
// and port pointer. When the receiver stalls, the grant beat holds in the
// output register; one more request beat is taken into the input register,
// and after that in_stall is raised until the output register frees up.
module separable_switch_allocator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ssa_pkg::in_beat_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ssa_pkg::out_beat_t out_data
);

`include "separable_switch_allocator_macros.svh"

  localparam int NP = ssa_pkg::NUM_PORTS;
  localparam int NV = ssa_pkg::NUM_VCS;
  localparam int PW = ssa_pkg::PORT_W;
  localparam int VW = ssa_pkg::VC_W;

  ssa_pkg::in_beat_t  s1_data_r;
  logic               s1_valid_r;
  ssa_pkg::out_beat_t out_data_r, out_data_nxt;
  logic               out_valid_r;

  logic [NP-1:0][VW-1:0] vc_ptr_r, vc_ptr_nxt;
  logic [NP-1:0][PW-1:0] port_ptr_r, port_ptr_nxt;

  logic out_free;
  logic advance;

  // Handshake: the output register frees when empty or being taken.
  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Unpacked views of the request beat.
  logic [NP-1:0][NV-1:0]         elig;
  logic [NP-1:0][NV-1:0][PW-1:0] tgt;

  assign elig = s1_data_r.vc_eligible;
  assign tgt  = s1_data_r.vc_target_ports;

  // Stage one: each input port picks one eligible VC.
  logic [NP-1:0]         has_req;
  logic [NP-1:0][VW-1:0] req_vc;
  logic [NP-1:0][PW-1:0] req_port;

  for (genvar p = 0; p < NP; p++) begin : g_in
    ssa_rr_arb #(.N(NV), .IW(VW)) u_vc_arb (
      .req (elig[p]),
      .ptr (vc_ptr_r[p]),
      .gnt (has_req[p]),
      .idx (req_vc[p])
    );
    assign req_port[p] = tgt[p][req_vc[p]];
  end

  // Stage two: each output port picks one requesting input port.
  logic [NP-1:0]         out_gnt;
  logic [NP-1:0][PW-1:0] out_idx;
  logic [NP-1:0][NP-1:0] out_req;

  for (genvar o = 0; o < NP; o++) begin : g_out
    for (genvar i = 0; i < NP; i++) begin : g_req
      assign out_req[o][i] = has_req[i] && (req_port[i] == PW'(o));
    end
    ssa_rr_arb #(.N(NP), .IW(PW)) u_port_arb (
      .req (out_req[o]),
      .ptr (port_ptr_r[o]),
      .gnt (out_gnt[o]),
      .idx (out_idx[o])
    );
  end

  // Grant beat and pointer updates.
  logic [NP-1:0][PW-1:0] gnt_in_nxt;
  logic [NP-1:0][VW-1:0] gnt_vc_nxt;
  logic [NP-1:0]         in_won;

  always_comb begin
    in_won       = '0;
    gnt_in_nxt   = '0;
    gnt_vc_nxt   = '0;
    port_ptr_nxt = port_ptr_r;
    vc_ptr_nxt   = vc_ptr_r;
    for (int o = 0; o < NP; o++) begin
      if (out_gnt[o]) begin
        gnt_in_nxt[o] = out_idx[o];
        gnt_vc_nxt[o] = req_vc[out_idx[o]];
        in_won[out_idx[o]] = 1'b1;
        if (out_idx[o] == PW'(NP - 1)) begin
          port_ptr_nxt[o] = '0;
        end else begin
          port_ptr_nxt[o] = out_idx[o] + PW'(1);
        end
      end
    end
    for (int p = 0; p < NP; p++) begin
      if (in_won[p]) begin
        if (req_vc[p] == VW'(NV - 1)) begin
          vc_ptr_nxt[p] = '0;
        end else begin
          vc_ptr_nxt[p] = req_vc[p] + VW'(1);
        end
      end
    end
    out_data_nxt.grant_valid   = out_gnt;
    out_data_nxt.grant_inports = gnt_in_nxt;
    out_data_nxt.grant_vcs     = gnt_vc_nxt;
  end

  // Control registers and pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      vc_ptr_r    <= '0;
      port_ptr_r  <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (advance) begin
        vc_ptr_r   <= vc_ptr_nxt;
        port_ptr_r <= port_ptr_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Checks: no input port is granted by two outputs; port pointers stay in range.
  logic [NP-1:0][PW-1:0] held_in;
  logic                  dup_grant;
  logic                  ptr_bad;

  assign held_in = out_data_r.grant_inports;

  always_comb begin
    dup_grant = 1'b0;
    ptr_bad   = 1'b0;
    for (int a = 0; a < NP; a++) begin
      if (port_ptr_r[a] >= PW'(NP)) begin
        ptr_bad = 1'b1;
      end
      for (int b = a + 1; b < NP; b++) begin
        if (out_data_r.grant_valid[a] && out_data_r.grant_valid[b] &&
            held_in[a] == held_in[b]) begin
          dup_grant = 1'b1;
        end
      end
    end
  end

  `SSA_ASSERT_NOW(a_one_grant_per_input, out_valid_r, !dup_grant)
  `SSA_ASSERT_NOW(a_port_ptr_range, 1'b1, !ptr_bad)
  `SSA_ASSERT_NEXT(a_ptr_hold, !advance, $stable(vc_ptr_r) && $stable(port_ptr_r))
  `SSA_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_r)

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

import ssa_pkg::*;

// Tracks the round-robin pointers of the allocator and keeps the grant beats
// still owed by the block, oldest first.
class grant_scoreboard;
  bit [VC_W-1:0]   vc_ptr[NUM_PORTS];
  bit [PORT_W-1:0] port_ptr[NUM_PORTS];
  out_beat_t       grants_due[$];
  int              mismatches;

  function new();
    foreach (vc_ptr[i]) vc_ptr[i] = '0;
    foreach (port_ptr[i]) port_ptr[i] = '0;
    mismatches = 0;
  endfunction

  // Two-stage separable allocation, updating the pointers of the winners.
  function out_beat_t allocate(in_beat_t b);
    bit        req[NUM_PORTS];
    int        req_out[NUM_PORTS];
    int        req_vc[NUM_PORTS];
    out_beat_t g;
    int        vc;
    int        slot;
    int        ip;
    g = '0;
    // Input stage: first eligible VC at or after the VC pointer.
    for (int p = 0; p < NUM_PORTS; p++) begin
      req[p] = 1'b0;
      req_out[p] = 0;
      req_vc[p] = 0;
      vc = int'(vc_ptr[p]) % NUM_VCS;
      for (int k = 0; k < NUM_VCS; k++) begin
        slot = p * NUM_VCS + vc;
        if (b.vc_eligible[slot]) begin
          req[p] = 1'b1;
          req_out[p] = int'(b.vc_target_ports[slot*PORT_W +: PORT_W]);
          req_vc[p] = vc;
          break;
        end
        vc = (vc + 1) % NUM_VCS;
      end
    end
    // Output stage: first requesting input at or after the port pointer.
    // Targets beyond the last port never match any output here.
    for (int o = 0; o < NUM_PORTS; o++) begin
      ip = int'(port_ptr[o]) % NUM_PORTS;
      for (int k = 0; k < NUM_PORTS; k++) begin
        if (req[ip] && req_out[ip] == o) begin
          g.grant_valid[o] = 1'b1;
          g.grant_inports[o*PORT_W +: PORT_W] = PORT_W'(ip);
          g.grant_vcs[o*VC_W +: VC_W] = VC_W'(req_vc[ip]);
          req[ip] = 1'b0;
          port_ptr[o] = PORT_W'((ip + 1) % NUM_PORTS);
          vc_ptr[ip] = VC_W'((req_vc[ip] + 1) % NUM_VCS);
          break;
        end
        ip = (ip + 1) % NUM_PORTS;
      end
    end
    return g;
  endfunction

  function void note_request(in_beat_t b);
    grants_due.push_back(allocate(b));
  endfunction

  function int pending();
    return grants_due.size();
  endfunction

  task report(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task check_grant(out_beat_t g);
    out_beat_t want;
    if (grants_due.size() == 0) begin
      report($sformatf("grant beat with none expected (valid %h)", g.grant_valid));
    end else begin
      want = grants_due.pop_front();
      if (g.grant_valid !== want.grant_valid)
        report($sformatf("grant_valid got %h, expected %h",
                         g.grant_valid, want.grant_valid));
      if (g.grant_inports !== want.grant_inports)
        report($sformatf("grant_inports got %h, expected %h",
                         g.grant_inports, want.grant_inports));
      if (g.grant_vcs !== want.grant_vcs)
        report($sformatf("grant_vcs got %h, expected %h",
                         g.grant_vcs, want.grant_vcs));
    end
  endtask
endclass

module tb_top;
  localparam int IDLE_LIMIT  = 3000;
  localparam int TAIL_CYCLES = 10;
  localparam int RAND_PER_PHASE = 477;
  localparam int HOLD_CYCLES = 400;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;

  grant_scoreboard sb = new();

  separable_switch_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Check every grant beat that the receiver takes.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_grant(out_data);
  end

  // Watchdog on cycles in which neither channel moves a beat.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog expired after %0d quiet cycles", IDLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // Offer one request beat, with random gaps before it, and wait for it.
  task automatic send_beat(input in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(b);
  endtask

  // Target code of each VC slot: base + port * port_step + vc * vc_step.
  function automatic logic [TARGET_W-1:0] fill_targets(int base, int port_step,
                                                       int vc_step);
    logic [TARGET_W-1:0] t;
    t = '0;
    for (int p = 0; p < NUM_PORTS; p++)
      for (int v = 0; v < NUM_VCS; v++)
        t[(p*NUM_VCS+v)*PORT_W +: PORT_W] = PORT_W'(base + p*port_step + v*vc_step);
    return t;
  endfunction

  // Mostly valid targets with varied request density; some pure noise.
  function automatic in_beat_t rand_request();
    in_beat_t b;
    int       density;
    int       slot;
    density = $urandom_range(3);
    b.vc_eligible = ELIG_W'($urandom);
    case (density)
      0: b.vc_eligible = b.vc_eligible & ELIG_W'($urandom);
      1: b.vc_eligible = b.vc_eligible | ELIG_W'($urandom);
      2: b.vc_eligible = b.vc_eligible & ELIG_W'($urandom) & ELIG_W'($urandom);
      default: ;
    endcase
    if ($urandom_range(99) < 5) begin
      b.vc_target_ports = TARGET_W'({$urandom, $urandom});
    end else begin
      for (slot = 0; slot < ELIG_W; slot++) begin
        if ($urandom_range(99) < 90)
          b.vc_target_ports[slot*PORT_W +: PORT_W] = PORT_W'($urandom_range(NUM_PORTS - 1));
        else
          b.vc_target_ports[slot*PORT_W +: PORT_W] =
            PORT_W'($urandom_range((1 << PORT_W) - 1, NUM_PORTS));
      end
    end
    return b;
  endfunction

  // Directed beats: empty, full contention, pointer rotation, disjoint
  // requests, out-of-range targets and sparse single-VC requests.
  task automatic run_directed();
    in_beat_t b;
    b.vc_eligible = '0;
    b.vc_target_ports = '0;
    send_beat(b);
    b.vc_eligible = '1;
    b.vc_target_ports = fill_targets(0, 0, 0);
    repeat (7) send_beat(b);
    b.vc_target_ports = fill_targets(0, 1, 0);
    repeat (2) send_beat(b);
    b.vc_target_ports = fill_targets(1, 1, 0);
    send_beat(b);
    b.vc_target_ports = fill_targets(0, 0, 1);
    repeat (3) send_beat(b);
    b.vc_target_ports = fill_targets(NUM_PORTS, 0, 0);
    send_beat(b);
    b.vc_target_ports = fill_targets(NUM_PORTS + 1, 0, 0);
    send_beat(b);
    b.vc_target_ports = '1;
    send_beat(b);
    b.vc_target_ports = fill_targets(NUM_PORTS - 1, 0, 0);
    send_beat(b);
    // One VC per port, at the port number modulo the VC count in each port.
    b.vc_eligible = '0;
    for (int p = 0; p < NUM_PORTS; p++) b.vc_eligible[p*NUM_VCS + p % NUM_VCS] = 1'b1;
    b.vc_target_ports = fill_targets(2, 3, 1);
    send_beat(b);
    b.vc_eligible = '0;
    for (int p = 0; p < NUM_PORTS; p++) b.vc_eligible[p*NUM_VCS + NUM_VCS - 1] = 1'b1;
    b.vc_target_ports = fill_targets(NUM_PORTS - 1, 0, 0);
    send_beat(b);
    b.vc_eligible = '1;
    b.vc_target_ports = fill_targets(3, 2, 3);
    send_beat(b);
  endtask

  // Main sequence: reset, directed beats, three random phases, drain.
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 10;
    recv_idle_pct = 67;
    run_directed();
    repeat (RAND_PER_PHASE) send_beat(rand_request());

    send_idle_pct = 67;
    recv_idle_pct = 10;
    repeat (RAND_PER_PHASE) send_beat(rand_request());

    // No idling; the receiver holds off for a while so the block backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = HOLD_CYCLES;
    repeat (RAND_PER_PHASE) send_beat(rand_request());
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
